// ===== hdl/gbn_pkg.sv =====
// gbn_pkg: shared types and codes of the go-back-n sender unit
// used by gbn_cfg_regs, gbn_step, go_back_n_sender_unit and gbn_checker
package gbn_pkg;

  typedef enum logic [1:0] {
    MODE_SEND  = 2'd0,
    MODE_ACK   = 2'd1,
    MODE_TICK  = 2'd2,
    MODE_START = 2'd3
  } mode_t;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_FIN  = 2'd2;

  localparam int CfgIndexW = 3;
  localparam int CfgDataW  = 32;

  localparam logic [CfgIndexW-1:0] CFG_WINDOW_SIZE   = 3'd0;
  localparam logic [CfgIndexW-1:0] CFG_FRAME_COUNT   = 3'd1;
  localparam logic [CfgIndexW-1:0] CFG_PAYLOAD_SIZE  = 3'd2;
  localparam logic [CfgIndexW-1:0] CFG_TOTAL_BYTES   = 3'd3;
  localparam logic [CfgIndexW-1:0] CFG_TIMEOUT_TICKS = 3'd4;

  typedef struct packed {
    logic [15:0] window_size;
    logic [15:0] frame_count;
    logic [10:0] payload_size;
    logic [31:0] total_bytes;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [15:0] next_seq;
    logic [15:0] last_acked;
    logic [31:0] byte_sum;
    logic [15:0] round_ticks;
    logic        done_flag;
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] frame_seq;
    logic [10:0] frame_len;
    logic [31:0] frame_offset;
  } frame_t;

endpackage

// ===== hdl/gbn_cfg_regs.sv =====
// gbn_cfg_regs: configuration register file of the go-back-n sender unit
// depends on gbn_pkg for the register indexes and cfg_t
module gbn_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [gbn_pkg::CfgIndexW-1:0]  cfg_index,
  input  logic [gbn_pkg::CfgDataW-1:0]   cfg_data,
  output gbn_pkg::cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_size   <= 16'd8;
      cfg.frame_count   <= 16'd0;
      cfg.payload_size  <= 11'd1024;
      cfg.total_bytes   <= 32'd0;
      cfg.timeout_ticks <= 16'd1000;
    end else if (cfg_write) begin
      unique case (cfg_index)
        gbn_pkg::CFG_WINDOW_SIZE:   cfg.window_size   <= cfg_data[15:0];
        gbn_pkg::CFG_FRAME_COUNT:   cfg.frame_count   <= cfg_data[15:0];
        gbn_pkg::CFG_PAYLOAD_SIZE:  cfg.payload_size  <= cfg_data[10:0];
        gbn_pkg::CFG_TOTAL_BYTES:   cfg.total_bytes   <= cfg_data;
        gbn_pkg::CFG_TIMEOUT_TICKS: cfg.timeout_ticks <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/gbn_step.sv =====
// gbn_step: event logic of the go-back-n sender, one event per cycle
// depends on gbn_pkg for mode codes, frame kinds and the state and config structs
module gbn_step #(
  parameter int MAX_PAYLOAD = 1024
) (
  input  gbn_pkg::cfg_t    cfg,
  input  gbn_pkg::state_t  st,
  input  gbn_pkg::mode_t   mode,
  input  logic [15:0]      ack_seq,
  input  logic [10:0]      ack_bytes,
  output gbn_pkg::state_t  st_next,
  output gbn_pkg::frame_t  frame
);

  logic [10:0] eff_payload;
  logic [26:0] prod;
  logic [31:0] offset;
  logic [31:0] remain;
  logic [10:0] len;
  logic        can_send;
  logic        ack_ok;
  logic [32:0] sum;
  logic [15:0] ticks;

  always_comb begin
    if (32'(cfg.payload_size) < 32'(MAX_PAYLOAD)) begin
      eff_payload = cfg.payload_size;
    end else begin
      eff_payload = 11'(MAX_PAYLOAD);
    end
  end

  assign prod   = {11'd0, st.next_seq} * {16'd0, eff_payload};
  assign offset = {5'd0, prod};
  assign remain = (cfg.total_bytes > offset) ? (cfg.total_bytes - offset) : 32'd0;
  assign len    = (remain < {21'd0, eff_payload}) ? remain[10:0] : eff_payload;

  // next_seq >= last_acked keeps the window distance from wrapping
  assign can_send = (st.next_seq < cfg.frame_count) && (st.next_seq >= st.last_acked) &&
                    ((st.next_seq - st.last_acked) < cfg.window_size);

  // 17-bit compare, so last_acked at all ones never matches
  assign ack_ok = ({1'b0, ack_seq} == ({1'b0, st.last_acked} + 17'd1)) &&
                  (ack_seq <= st.next_seq);

  assign sum   = {1'b0, st.byte_sum} + {22'd0, ack_bytes};
  assign ticks = (st.round_ticks != 16'hFFFF) ? (st.round_ticks + 16'd1) : 16'hFFFF;

  always_comb begin
    st_next = st;
    frame   = '0;
    if (mode == gbn_pkg::MODE_START) begin
      st_next = '0;
    end else if (!st.done_flag) begin
      unique case (mode)
        gbn_pkg::MODE_SEND: begin
          if (can_send) begin
            frame.kind         = gbn_pkg::KIND_DATA;
            frame.frame_seq    = st.next_seq;
            frame.frame_len    = len;
            frame.frame_offset = offset;
            st_next.next_seq   = st.next_seq + 16'd1;
          end
        end
        gbn_pkg::MODE_ACK: begin
          if (ack_ok) begin
            st_next.last_acked = ack_seq;
            st_next.byte_sum   = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          end
        end
        gbn_pkg::MODE_TICK: begin
          if (ticks > cfg.timeout_ticks) begin
            st_next.round_ticks = 16'd0;
            if (st.last_acked == cfg.frame_count) begin
              frame.kind        = gbn_pkg::KIND_FIN;
              frame.frame_seq   = cfg.frame_count;
              st_next.done_flag = 1'b1;
            end else begin
              // go back to the first unacknowledged frame
              st_next.next_seq = st.last_acked;
            end
          end else begin
            st_next.round_ticks = ticks;
          end
        end
        gbn_pkg::MODE_START: ;
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/go_back_n_sender_unit.sv =====
// go_back_n_sender_unit: top level of the go-back-n sender control
// depends on gbn_pkg, gbn_cfg_regs and gbn_step
//
// usage
//   events (send slot, acknowledgement, timer tick, start) come in on the
//   in_valid / in_ready channel; every event gives exactly one result on the
//   out_valid / out_ready channel: a frame descriptor (kind, frame_seq,
//   frame_len, frame_offset) and the status after the event (acked_bytes,
//   acked_through, finished)
//   configuration is written through cfg_write / cfg_index / cfg_data while
//   no event is in flight; writes to unused indexes are dropped
//   out_valid rises once an input transfer has loaded the input register and
//   the event has then moved into the result register, which takes it only
//   while it is empty or its result is being taken
//   throughput is one event per cycle without stalls; the sender state is
//   updated in the same cycle as the result register, so each event sees the
//   previous one; a stalled receiver holds the result; the input register
//   still takes one more event; in_ready drops only while both stages are full
//   reset clears the sender state and both stages and loads the register
//   defaults: window 8, no frames, payload 1024, no bytes, timeout 1000
module go_back_n_sender_unit #(
  parameter int MAX_PAYLOAD = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [gbn_pkg::CfgIndexW-1:0]  cfg_index,
  input  logic [gbn_pkg::CfgDataW-1:0]   cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     mode,
  input  logic [15:0]                    ack_seq,
  input  logic [10:0]                    ack_bytes,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     kind,
  output logic [15:0]                    frame_seq,
  output logic [10:0]                    frame_len,
  output logic [31:0]                    frame_offset,
  output logic [31:0]                    acked_bytes,
  output logic [15:0]                    acked_through,
  output logic                           finished
);

  gbn_pkg::cfg_t   cfg;
  gbn_pkg::state_t st;
  gbn_pkg::state_t st_next;
  gbn_pkg::frame_t frame;

  logic            in_q_valid;
  gbn_pkg::mode_t  in_q_mode;
  logic [15:0]     in_q_ack_seq;
  logic [10:0]     in_q_ack_bytes;
  logic            advance;

  gbn_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  gbn_step #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_step (
    .cfg       (cfg),
    .st        (st),
    .mode      (in_q_mode),
    .ack_seq   (in_q_ack_seq),
    .ack_bytes (in_q_ack_bytes),
    .st_next   (st_next),
    .frame     (frame)
  );

  assign advance  = !out_valid || out_ready;
  assign in_ready = !in_q_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      in_q_mode      <= gbn_pkg::mode_t'(mode);
      in_q_ack_seq   <= ack_seq;
      in_q_ack_bytes <= ack_bytes;
    end
  end

  // sender state and result register move together
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_q_valid;
      if (in_q_valid) begin
        st <= st_next;
      end
    end
    if (advance && in_q_valid) begin
      kind          <= frame.kind;
      frame_seq     <= frame.frame_seq;
      frame_len     <= frame.frame_len;
      frame_offset  <= frame.frame_offset;
      acked_bytes   <= st_next.byte_sum;
      acked_through <= st_next.last_acked;
      finished      <= st_next.done_flag;
    end
  end

endmodule

// ===== hdl/gbn_checker.sv =====
// gbn_checker: port-level assertions for go_back_n_sender_unit, bound to the top level
// depends on gbn_pkg for the frame kind codes
module gbn_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  kind,
  input logic [15:0] frame_seq,
  input logic [10:0] frame_len,
  input logic [31:0] frame_offset,
  input logic [31:0] acked_bytes,
  input logic [15:0] acked_through,
  input logic        finished
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(frame_seq) &&
      $stable(frame_len) && $stable(frame_offset) && $stable(acked_bytes) &&
      $stable(acked_through) && $stable(finished))
    else $error("result changed while stalled");

  // no frame means an all-zero descriptor
  assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == gbn_pkg::KIND_NONE |->
      frame_seq == 16'd0 && frame_len == 11'd0 && frame_offset == 32'd0)
    else $error("empty result carries a descriptor");

  // fin sets finished and carries no length or offset
  assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == gbn_pkg::KIND_FIN |->
      finished && frame_len == 11'd0 && frame_offset == 32'd0)
    else $error("bad fin result");

  // no data frame after the transfer is finished
  assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == gbn_pkg::KIND_DATA |-> !finished)
    else $error("data frame issued after fin");

endmodule

bind go_back_n_sender_unit gbn_checker u_gbn_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .kind          (kind),
  .frame_seq     (frame_seq),
  .frame_len     (frame_len),
  .frame_offset  (frame_offset),
  .acked_bytes   (acked_bytes),
  .acked_through (acked_through),
  .finished      (finished)
);

// ===== test/gbn_checker.sv =====
// gbn_scoreboard: watches the event, result and register ports of the go-back-n sender unit,
// keeps its own model of the sender and compares every result transfer against it
// depends on gbn_pkg
module gbn_scoreboard #(
  parameter int MAX_PAYLOAD = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [gbn_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [gbn_pkg::CfgDataW-1:0]  cfg_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [1:0]                    mode,
  input  logic [15:0]                   ack_seq,
  input  logic [10:0]                   ack_bytes,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [1:0]                    kind,
  input  logic [15:0]                   frame_seq,
  input  logic [10:0]                   frame_len,
  input  logic [31:0]                   frame_offset,
  input  logic [31:0]                   acked_bytes,
  input  logic [15:0]                   acked_through,
  input  logic                          finished,
  output int                            error_count,
  output int                            outstanding
);
  import gbn_pkg::*;

  typedef struct packed {
    frame_t      frame;
    logic [31:0] byte_total;
    logic [15:0] ack_point;
    logic        fin_done;
  } sender_report_t;

  sender_report_t predicted_reports[$];

  // register copies
  logic [15:0] win_r;
  logic [15:0] count_r;
  logic [10:0] pay_r;
  logic [31:0] total_r;
  logic [15:0] timeout_r;

  // sender copy
  logic [15:0] nseq;
  logic [15:0] lack;
  logic [31:0] bsum;
  logic [15:0] rticks;
  logic        fin_sent;

  initial begin
    error_count = 0;
    outstanding = 0;
  end

  task automatic clear_sender();
    nseq     = '0;
    lack     = '0;
    bsum     = '0;
    rticks   = '0;
    fin_sent = 1'b0;
  endtask

  task automatic load_register(input logic [CfgIndexW-1:0] idx, input logic [31:0] data);
    case (idx)
      CFG_WINDOW_SIZE:   win_r     = data[15:0];
      CFG_FRAME_COUNT:   count_r   = data[15:0];
      CFG_PAYLOAD_SIZE:  pay_r     = data[10:0];
      CFG_TOTAL_BYTES:   total_r   = data;
      CFG_TIMEOUT_TICKS: timeout_r = data[15:0];
      default: ;
    endcase
  endtask

  task automatic step_sender(input mode_t ev, input logic [15:0] aseq,
                             input logic [10:0] abytes);
    sender_report_t rep;
    logic [31:0]    pay;
    logic [31:0]    off;
    logic [31:0]    rem;
    logic [32:0]    acc;
    logic [15:0]    t;
    rep = '0;
    if (ev == MODE_START) begin
      clear_sender();
    end else if (!fin_sent) begin
      case (ev)
        MODE_SEND: begin
          if (nseq < count_r && nseq >= lack && (nseq - lack) < win_r) begin
            pay = (pay_r < MAX_PAYLOAD) ? 32'(pay_r) : 32'(MAX_PAYLOAD);
            off = nseq * pay;
            rem = (total_r > off) ? total_r - off : 32'd0;
            rep.frame.kind         = KIND_DATA;
            rep.frame.frame_seq    = nseq;
            rep.frame.frame_len    = (rem < pay) ? rem[10:0] : pay[10:0];
            rep.frame.frame_offset = off;
            nseq = nseq + 16'd1;
          end
        end
        MODE_ACK: begin
          // only the next in-order ack of an already sent frame counts
          if ({1'b0, aseq} == {1'b0, lack} + 17'd1 && aseq <= nseq) begin
            acc  = {1'b0, bsum} + 33'(abytes);
            lack = aseq;
            bsum = acc[32] ? 32'hFFFF_FFFF : acc[31:0];
          end
        end
        MODE_TICK: begin
          t = (rticks != 16'hFFFF) ? rticks + 16'd1 : rticks;
          if (t > timeout_r) begin
            rticks = '0;
            if (lack == count_r) begin
              rep.frame.kind      = KIND_FIN;
              rep.frame.frame_seq = count_r;
              fin_sent            = 1'b1;
            end else begin
              nseq = lack;
            end
          end else begin
            rticks = t;
          end
        end
        default: ;
      endcase
    end
    rep.byte_total = bsum;
    rep.ack_point  = lack;
    rep.fin_done   = fin_sent;
    predicted_reports.push_back(rep);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    sender_report_t want;
    if (rst) begin
      win_r     = 16'd8;
      count_r   = 16'd0;
      pay_r     = 11'd1024;
      total_r   = 32'd0;
      timeout_r = 16'd1000;
      clear_sender();
      predicted_reports.delete();
    end else begin
      if (cfg_write) load_register(cfg_index, cfg_data);
      if (out_valid && out_ready) begin
        if (predicted_reports.size() == 0) begin
          error_count++;
          $display("%0t: result transfer with nothing expected, expected none, got kind %0h",
                   $time, kind);
        end else begin
          want = predicted_reports.pop_front();
          check_field("kind", 32'(want.frame.kind), 32'(kind));
          check_field("frame_seq", 32'(want.frame.frame_seq), 32'(frame_seq));
          check_field("frame_len", 32'(want.frame.frame_len), 32'(frame_len));
          check_field("frame_offset", want.frame.frame_offset, frame_offset);
          check_field("acked_bytes", want.byte_total, acked_bytes);
          check_field("acked_through", 32'(want.ack_point), 32'(acked_through));
          check_field("finished", 32'(want.fin_done), 32'(finished));
        end
      end
      if (in_valid && in_ready) step_sender(mode_t'(mode), ack_seq, ack_bytes);
    end
    outstanding = predicted_reports.size();
  end

endmodule

// ===== test/go_back_n_sender_unit_tb.sv =====
// go_back_n_sender_unit_tb: drives events and register writes into the go-back-n sender unit
// with random gaps and receiver stalls; depends on gbn_pkg, go_back_n_sender_unit, gbn_scoreboard
module go_back_n_sender_unit_tb;
  import gbn_pkg::*;

  localparam int CycleLimit = 1_500_000;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [1:0]           mode      = MODE_SEND;
  logic [15:0]          ack_seq   = '0;
  logic [10:0]          ack_bytes = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b1;
  logic [1:0]           kind;
  logic [15:0]          frame_seq;
  logic [10:0]          frame_len;
  logic [31:0]          frame_offset;
  logic [31:0]          acked_bytes;
  logic [15:0]          acked_through;
  logic                 finished;

  int          error_count;
  int          outstanding;
  int          cycle_cnt      = 0;
  int          sink_wait      = 0;
  int          src_idle_pct   = 0;
  int          sink_stall_pct = 0;
  logic [15:0] acked_seen     = '0;

  go_back_n_sender_unit u_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .ack_seq(ack_seq), .ack_bytes(ack_bytes),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .frame_seq(frame_seq), .frame_len(frame_len), .frame_offset(frame_offset),
    .acked_bytes(acked_bytes), .acked_through(acked_through), .finished(finished)
  );

  gbn_scoreboard u_checker (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .ack_seq(ack_seq), .ack_bytes(ack_bytes),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .frame_seq(frame_seq), .frame_len(frame_len), .frame_offset(frame_offset),
    .acked_bytes(acked_bytes), .acked_through(acked_through), .finished(finished),
    .error_count(error_count), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(1, 3);
    else if (r < 9) return $urandom_range(4, 8);
    else return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b1;
      sink_wait <= 0;
    end else if (sink_wait != 0) begin
      sink_wait <= sink_wait - 1;
    end else if ($urandom_range(0, 99) < sink_stall_pct) begin
      out_ready <= 1'b0;
      sink_wait <= gap_len();
    end else begin
      out_ready <= 1'b1;
    end
  end

  // last ack point seen on the result side, used to aim acks
  always @(posedge clk) begin
    if (out_valid && out_ready) acked_seen <= acked_through;
  end

  task automatic issue_event(input mode_t ev, input logic [15:0] s, input logic [10:0] b);
    int g;
    mode      <= ev;
    ack_seq   <= s;
    ack_bytes <= b;
    in_valid  <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      g = gap_len();
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CfgIndexW-1:0] idx, input logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // upper bits beyond a register's width carry noise
  task automatic configure(input logic [15:0] win, input logic [15:0] cnt,
                           input logic [10:0] pay, input logic [31:0] total,
                           input logic [15:0] tmo);
    set_reg(CFG_WINDOW_SIZE, {16'($urandom), win});
    set_reg(CFG_FRAME_COUNT, {16'($urandom), cnt});
    set_reg(CFG_PAYLOAD_SIZE, {21'($urandom), pay});
    set_reg(CFG_TOTAL_BYTES, total);
    set_reg(CFG_TIMEOUT_TICKS, {16'($urandom), tmo});
    cfg_write <= 1'b0;
  endtask

  task automatic run_directed();
    configure(16'd2, 16'd3, 11'd1000, 32'd2500, 16'd1);
    issue_event(MODE_START, 16'hFFFF, 11'h7FF);
    issue_event(MODE_ACK, 16'd1, 11'd10);     // beyond anything sent
    issue_event(MODE_SEND, 16'd0, 11'd0);
    issue_event(MODE_SEND, 16'd0, 11'd0);
    issue_event(MODE_SEND, 16'd0, 11'd0);     // window full
    issue_event(MODE_ACK, 16'd5, 11'd100);
    issue_event(MODE_ACK, 16'd2, 11'd100);    // out of order
    issue_event(MODE_ACK, 16'd1, 11'd1000);
    issue_event(MODE_SEND, 16'd0, 11'd0);     // short last frame
    issue_event(MODE_SEND, 16'd0, 11'd0);     // all frames out
    issue_event(MODE_ACK, 16'd3, 11'd0);
    issue_event(MODE_ACK, 16'd2, 11'd1024);
    issue_event(MODE_TICK, 16'd0, 11'd0);
    issue_event(MODE_TICK, 16'd0, 11'd0);     // expiry, go back
    issue_event(MODE_SEND, 16'd0, 11'd0);
    issue_event(MODE_ACK, 16'd3, 11'h7FF);
    issue_event(MODE_TICK, 16'd0, 11'd0);
    issue_event(MODE_TICK, 16'd0, 11'd0);     // fin
    issue_event(MODE_SEND, 16'd0, 11'd0);
    issue_event(MODE_ACK, 16'd4, 11'd5);
    issue_event(MODE_TICK, 16'd0, 11'd0);
    issue_event(MODE_START, 16'd0, 11'd0);
  endtask

  task automatic run_phase(input int phase_no, input int n_items);
    logic [15:0] win;
    logic [15:0] cnt;
    logic [10:0] pay;
    logic [31:0] total;
    logic [15:0] tmo;
    logic [15:0] s;
    logic [10:0] b;
    int          r;
    case (phase_no % 6)
      0:       win = 16'd0;
      1:       win = 16'hFFFF;
      default: win = 16'($urandom_range(1, 6));
    endcase
    case (phase_no % 5)
      0:       cnt = 16'd0;
      1:       cnt = 16'd1;
      default: cnt = 16'($urandom_range(2, 12));
    endcase
    case (phase_no % 4)
      0:       pay = 11'd0;
      1:       pay = 11'h7FF;
      2:       pay = 11'd1024;
      default: pay = 11'($urandom_range(1, 2047));
    endcase
    case (phase_no % 4)
      0:       total = 32'hFFFF_FFFF;
      1:       total = 32'd0;
      default: total = 32'($urandom_range(0, 16000));
    endcase
    case (phase_no % 7)
      0:       tmo = 16'd0;
      1:       tmo = 16'hFFFF;
      default: tmo = 16'($urandom_range(1, 12));
    endcase
    case (phase_no % 3)
      0: begin
        src_idle_pct   = 0;
        sink_stall_pct = 0;
      end
      1: begin
        src_idle_pct   = 30;
        sink_stall_pct = 25;
      end
      default: begin
        src_idle_pct   = 60;
        sink_stall_pct = 50;
      end
    endcase
    configure(win, cnt, pay, total, tmo);
    issue_event(MODE_START, 16'($urandom), 11'($urandom));
    repeat (n_items) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        issue_event(mode_t'($urandom_range(0, 3)), 16'($urandom), 11'($urandom));
      end else if (r < 48) begin
        issue_event(MODE_SEND, 16'($urandom), 11'($urandom));
      end else if (r < 78) begin
        s = ($urandom_range(0, 99) < 85) ? acked_seen + 16'd1
                                         : acked_seen + 16'($urandom_range(0, 3));
        b = ($urandom_range(0, 99) < 80) ? 11'($urandom_range(0, 1024))
                                         : 11'($urandom_range(1025, 2047));
        issue_event(MODE_ACK, s, b);
      end else if (r < 97) begin
        issue_event(MODE_TICK, 16'($urandom), 11'($urandom));
      end else begin
        issue_event(MODE_START, 16'($urandom), 11'($urandom));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    wait_idle();
    for (int p = 0; p < 13; p++) begin
      run_phase(p, 52);
      wait_idle();
    end
    src_idle_pct   = 40;
    sink_stall_pct = 40;
    run_phase(13, 30);
    wait_idle();
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
